### hdl/smtp_reply_capability_parser_assert.svh
// Assertion macros shared by the SMTP reply parser modules.
// Expects clk and rst_n in the scope of each use.
`ifndef SMTP_REPLY_CAPABILITY_PARSER_ASSERT_SVH
`define SMTP_REPLY_CAPABILITY_PARSER_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define SRCP_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smtp reply parser: assertion failed");

// Next-cycle implication.
`define SRCP_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smtp reply parser: assertion failed");

`endif

### hdl/smtp_rcp_pkg.sv
// Shared types, constants and helper functions of the SMTP reply parser.
// No dependencies; imported by every module of the block.
package smtp_rcp_pkg;

    localparam int SIZE_BITS_DEF = 32;
    localparam int OUT_SIZE_W    = 32;
    localparam int CODE_W        = 10;
    localparam int POS_W         = 5;
    localparam logic [POS_W-1:0] POS_MAX = 5'd31;

    // Column positions inside a reply line
    localparam int POS_SEP = 3;
    localparam int POS_KW  = 4;
    localparam int POS_ARG = 8;

    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 48;
    localparam int OUT_TUSER_W = 1;

    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_0     = 8'h30;
    localparam logic [7:0] CH_9     = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;
    localparam logic [7:0] CASE_OFS = 8'h20;

    // Keywords in match priority order
    localparam int KW_COUNT     = 5;
    localparam int KW_MAX_LEN   = 10;
    localparam int KW_STARTTLS  = 0;
    localparam int KW_EIGHTBIT  = 1;
    localparam int KW_PIPELINE  = 2;
    localparam int KW_SIZE      = 3;
    localparam int KW_AUTH      = 4;
    localparam logic [KW_COUNT-1:0] KW_ALL_LIVE = '1;

    // Text left-justified, padded with spaces beyond the keyword length
    localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
        "STARTTLS  ", "8BITMIME  ", "PIPELINING", "SIZE      ", "AUTH      "
    };
    localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{5'd8, 5'd8, 5'd10, 5'd4, 5'd4};

    // Capability flag bits
    localparam int CAP_STARTTLS = 0;
    localparam int CAP_EIGHTBIT = 1;
    localparam int CAP_PIPELINE = 2;
    localparam int CAP_AUTH     = 3;
    localparam int CAP_COUNT    = 4;

    typedef enum logic [1:0] {
        SZ_WAIT,
        SZ_DIGITS,
        SZ_DONE
    } size_phase_t;

    typedef struct packed {
        logic       ehlo_mode;
        logic       start_reply;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        logic [CODE_W-1:0]     reply_code;
        logic                  line_continues;
        logic                  reply_done;
        logic                  parse_error;
        logic                  cap_starttls;
        logic                  cap_eightbit;
        logic                  cap_pipelining;
        logic                  cap_auth;
        logic [OUT_SIZE_W-1:0] max_message_size;
    } result_t;

    typedef struct packed {
        logic    take;
        logic    emit;
        result_t res;
    } parse_out_t;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) ? c - CASE_OFS : c;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    function automatic logic [7:0] kw_char(input int unsigned k, input logic [POS_W-1:0] off);
        logic [KW_MAX_LEN*8-1:0] t;
        t = KW_TEXT[k];
        if (off < POS_W'(KW_MAX_LEN))
            return t[8*(KW_MAX_LEN-1-int'(off)) +: 8];
        return 8'h00;
    endfunction

endpackage

### hdl/smtp_rcp_kw_match.sv
// Keyword candidate filter of the SMTP reply parser.
// Depends on smtp_rcp_pkg for the keyword table.
module smtp_rcp_kw_match
    import smtp_rcp_pkg::*;
(
    input  logic [POS_W-1:0]    pos,
    input  logic [7:0]          ch,
    input  logic [KW_COUNT-1:0] cand_in,
    output logic [KW_COUNT-1:0] cand_out,
    output logic [KW_COUNT-1:0] hit
);

    logic [POS_W-1:0] off;

    assign off = pos - POS_W'(POS_KW);

    // Drop a keyword on the first mismatching character inside its length
    for (genvar k = 0; k < KW_COUNT; k++) begin : g_kw
        assign cand_out[k] = cand_in[k] &&
                             !((off < KW_LEN[k]) && (kw_char(k, off) != ch));
        assign hit[k]      = cand_in[k] && (pos >= POS_W'(POS_KW) + KW_LEN[k]);
    end

endmodule

### hdl/smtp_rcp_size_step.sv
// One decimal digit step of the SIZE value: acc * 10 + digit, saturating.
// Depends on smtp_rcp_pkg.
module smtp_rcp_size_step
    import smtp_rcp_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic [SIZE_BITS-1:0] acc,
    input  logic [3:0]           digit,
    output logic [SIZE_BITS-1:0] acc_next
);

    localparam int WIDE_W = SIZE_BITS + 4;

    logic [WIDE_W-1:0] wide;

    assign wide = (WIDE_W'(acc) << 3) + (WIDE_W'(acc) << 1) + WIDE_W'(digit);
    assign acc_next = (|wide[WIDE_W-1:SIZE_BITS]) ? '1 : wide[SIZE_BITS-1:0];

endmodule

### hdl/smtp_rcp_parser.sv
// Line and reply state of the SMTP reply parser; one byte per cycle, except when a line feed waits for a free output.
// Depends on smtp_rcp_pkg, smtp_rcp_kw_match and smtp_rcp_size_step.
`include "smtp_reply_capability_parser_assert.svh"

module smtp_rcp_parser
    import smtp_rcp_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       item_valid,
    input  item_t      item,
    input  logic       out_free,
    output parse_out_t po
);

    localparam int EXT_W = (SIZE_BITS > OUT_SIZE_W) ? SIZE_BITS : OUT_SIZE_W;

    logic [POS_W-1:0]     pos_reg,     pos_next,  pos_e;
    logic [CODE_W-1:0]    code_reg,    code_next, code_e, code_step;
    logic                 bad_reg,     bad_next,  bad_e;
    logic                 dash_reg,    dash_next, dash_e;
    logic                 first_reg,   first_next, first_e;
    logic                 ehlo_reg,    ehlo_next, ehlo_e;
    logic                 aborted_reg, aborted_next, aborted_e;
    logic [KW_COUNT-1:0]  cand_reg,    cand_next, cand_e, cand_upd, kw_hit;
    size_phase_t          sph_reg,     sph_next,  sph_e;
    logic [SIZE_BITS-1:0] sacc_reg,    sacc_next, sacc_e, sacc_step;
    logic [CAP_COUNT-1:0] caps_reg,    caps_next, caps_e;
    logic [SIZE_BITS-1:0] sreg_reg,    sreg_next, sreg_e;
    logic [EXT_W-1:0]     sreg_ext;

    logic       st;
    logic [7:0] ch;
    logic       digit;
    logic       is_text;
    logic       is_eol;
    logic       err;
    logic       done;
    logic       commit;

    smtp_rcp_kw_match u_kw (
        .pos      (pos_e),
        .ch       (upcase(item.data_byte)),
        .cand_in  (cand_e),
        .cand_out (cand_upd),
        .hit      (kw_hit)
    );

    smtp_rcp_size_step #(
        .SIZE_BITS (SIZE_BITS)
    ) u_size (
        .acc      (sacc_e),
        .digit    (item.data_byte[3:0]),
        .acc_next (sacc_step)
    );

    always_comb
    begin
        st = item.start_reply;
        ch = item.data_byte;
        digit = is_digit(ch);

        // A reply start clears line and reply state before its byte is taken
        pos_e     = st ? '0 : pos_reg;
        code_e    = st ? '0 : code_reg;
        bad_e     = st ? 1'b0 : bad_reg;
        dash_e    = st ? 1'b0 : dash_reg;
        cand_e    = st ? KW_ALL_LIVE : cand_reg;
        sph_e     = st ? SZ_WAIT : sph_reg;
        sacc_e    = st ? '0 : sacc_reg;
        first_e   = st ? 1'b1 : first_reg;
        ehlo_e    = st ? item.ehlo_mode : ehlo_reg;
        aborted_e = st ? 1'b0 : aborted_reg;
        caps_e    = (st && item.ehlo_mode) ? '0 : caps_reg;
        sreg_e    = (st && item.ehlo_mode) ? '0 : sreg_reg;

        code_step = {code_e[6:0], 3'b000} + {code_e[8:0], 1'b0} + CODE_W'(ch[3:0]);

        is_text = !aborted_e && (ch != CH_CR) && (ch != CH_LF);
        is_eol  = !aborted_e && (ch == CH_LF);

        err    = (pos_e < POS_W'(POS_SEP)) || bad_e;
        done   = err || !dash_e;
        commit = !err && ehlo_e && !first_e && (pos_e > POS_W'(POS_KW));

        pos_next     = pos_e;
        code_next    = code_e;
        bad_next     = bad_e;
        dash_next    = dash_e;
        cand_next    = cand_e;
        sph_next     = sph_e;
        sacc_next    = sacc_e;
        first_next   = first_e;
        ehlo_next    = ehlo_e;
        aborted_next = aborted_e;
        caps_next    = caps_e;
        sreg_next    = sreg_e;

        if (is_text)
        begin
            if (pos_e < POS_W'(POS_SEP))
            begin
                if (digit)
                    code_next = code_step;
                else
                    bad_next = 1'b1;
            end
            else if (pos_e == POS_W'(POS_SEP))
            begin
                dash_next = (ch == CH_DASH);
            end
            else
            begin
                cand_next = cand_upd;
                if ((pos_e >= POS_W'(POS_ARG)) && cand_upd[KW_SIZE])
                begin
                    case (sph_e)
                        SZ_WAIT:
                        begin
                            if (digit)
                            begin
                                sacc_next = SIZE_BITS'(ch[3:0]);
                                sph_next  = SZ_DIGITS;
                            end
                            else if (ch != CH_SPACE)
                            begin
                                sph_next = SZ_DONE;
                            end
                        end
                        SZ_DIGITS:
                        begin
                            if (digit)
                                sacc_next = sacc_step;
                            else
                                sph_next = SZ_DONE;
                        end
                        default:
                        begin
                            sph_next = sph_e;
                        end
                    endcase
                end
            end
            if (pos_e != POS_MAX)
                pos_next = pos_e + 1'b1;
        end

        if (is_eol)
        begin
            // Skip the greeting line of an EHLO reply
            if (!err && ehlo_e && first_e)
                first_next = 1'b0;
            if (commit)
            begin
                if (kw_hit[KW_STARTTLS])
                    caps_next[CAP_STARTTLS] = 1'b1;
                else if (kw_hit[KW_EIGHTBIT])
                    caps_next[CAP_EIGHTBIT] = 1'b1;
                else if (kw_hit[KW_PIPELINE])
                    caps_next[CAP_PIPELINE] = 1'b1;
                else if (kw_hit[KW_SIZE])
                    sreg_next = sacc_e;
                else if (kw_hit[KW_AUTH])
                    caps_next[CAP_AUTH] = 1'b1;
            end
            pos_next     = '0;
            code_next    = '0;
            bad_next     = 1'b0;
            dash_next    = 1'b0;
            cand_next    = KW_ALL_LIVE;
            sph_next     = SZ_WAIT;
            sacc_next    = '0;
            aborted_next = done;
        end

        sreg_ext = EXT_W'(sreg_next);

        po.emit = item_valid && is_eol;
        po.take = item_valid && (!is_eol || out_free);
        po.res.reply_code       = err ? '0 : code_e;
        po.res.line_continues   = !err && dash_e;
        po.res.reply_done       = done;
        po.res.parse_error      = err;
        po.res.cap_starttls     = caps_next[CAP_STARTTLS];
        po.res.cap_eightbit     = caps_next[CAP_EIGHTBIT];
        po.res.cap_pipelining   = caps_next[CAP_PIPELINE];
        po.res.cap_auth         = caps_next[CAP_AUTH];
        po.res.max_message_size = (sreg_ext > EXT_W'({OUT_SIZE_W{1'b1}})) ?
                                  '1 : sreg_ext[OUT_SIZE_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            code_reg    <= '0;
            bad_reg     <= 1'b0;
            dash_reg    <= 1'b0;
            first_reg   <= 1'b1;
            ehlo_reg    <= 1'b0;
            aborted_reg <= 1'b0;
            cand_reg    <= KW_ALL_LIVE;
            sph_reg     <= SZ_WAIT;
            sacc_reg    <= '0;
            caps_reg    <= '0;
            sreg_reg    <= '0;
        end
        else if (po.take)
        begin
            pos_reg     <= pos_next;
            code_reg    <= code_next;
            bad_reg     <= bad_next;
            dash_reg    <= dash_next;
            first_reg   <= first_next;
            ehlo_reg    <= ehlo_next;
            aborted_reg <= aborted_next;
            cand_reg    <= cand_next;
            sph_reg     <= sph_next;
            sacc_reg    <= sacc_next;
            caps_reg    <= caps_next;
            sreg_reg    <= sreg_next;
        end
    end

    `SRCP_ASSERT_NXT(a_done_blocks, po.take && po.emit && po.res.reply_done, aborted_reg)
    `SRCP_ASSERT_IMP(a_stall_only_on_result, item_valid && !po.take, po.emit && !out_free)

endmodule

### hdl/smtp_reply_capability_parser.sv
// SMTP reply parser: takes reply text one byte per item and gives one result item per line
// feed (code, continuation, reply done, parse error, EHLO capabilities and SIZE value).
// A byte is registered on input and then parsed into the output register, so a result passes
// through the input register and the output register before it is offered on the output.
// One byte is taken every cycle;
// the only stall is a line feed meeting a full output register that is not being drained.
// Bytes after a finished reply or a parse error are dropped until the next reply start.
`include "smtp_reply_capability_parser_assert.svh"

module smtp_reply_capability_parser
    import smtp_rcp_pkg::*;
#(
    parameter int SIZE_BITS = SIZE_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] data_byte
    input  logic [IN_TUSER_W-1:0]  s_axis_tuser,  // [0] start_reply, [1] ehlo_mode
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [9:0] reply_code, [10] line_continues, [11] cap_starttls, [12] cap_eightbit,
    // [13] cap_pipelining, [14] cap_auth, [46:15] max_message_size, [47] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,  // [0] parse_error
    output logic                   m_axis_tlast   // reply_done
);

    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg, out_valid_next;
    result_t    out_res_reg;
    logic       out_free;
    parse_out_t po;

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || po.take;

    smtp_rcp_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .out_free   (out_free),
        .po         (po)
    );

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_item_reg.data_byte   <= s_axis_tdata;
            in_item_reg.start_reply <= s_axis_tuser[0];
            in_item_reg.ehlo_mode   <= s_axis_tuser[1];
        end
    end

    // Output register: load on a line end, drop once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (po.take && po.emit)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (po.take && po.emit)
            out_res_reg <= po.res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0,
                            out_res_reg.max_message_size,
                            out_res_reg.cap_auth,
                            out_res_reg.cap_pipelining,
                            out_res_reg.cap_eightbit,
                            out_res_reg.cap_starttls,
                            out_res_reg.line_continues,
                            out_res_reg.reply_code};
    assign m_axis_tuser  = out_res_reg.parse_error;
    assign m_axis_tlast  = out_res_reg.reply_done;

    `SRCP_ASSERT_IMP(a_err_ends_reply, m_axis_tvalid && m_axis_tuser[0], m_axis_tlast)
    `SRCP_ASSERT_IMP(a_err_no_code, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata[10:0] == '0)
    `SRCP_ASSERT_IMP(a_cont_not_last, m_axis_tvalid && m_axis_tdata[10], !m_axis_tlast)
    `SRCP_ASSERT_IMP(a_stall_needs_full, !s_axis_tready, in_valid_reg && out_valid_reg)

endmodule
